[sv/buch_pkg.sv]
`timescale 1ns / 1ps
package buch_pkg;
  localparam int KeyW = 31;
  localparam int RelocW = 8;
  localparam int TableSlots = 1024;
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_REMOVE = 2'd2;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam logic [2:0] REG_SEED0 = 3'd0;
  localparam logic [2:0] REG_SEED1 = 3'd1;
  localparam logic [2:0] REG_SEED2 = 3'd2;
  localparam logic [2:0] REG_SEED3 = 3'd3;
  localparam logic [2:0] REG_MAXREL = 3'd4;
  typedef logic [KeyW-1:0] key_t;
endpackage

[sv/bubble_up_cuckoo_hash_table.sv]
`timescale 1ns / 1ps
// Cuckoo hash table with one entry per slot, keyed by 31-bit keys, NUM_HASH xor-seeded hashes
// and bubble-up relocation on insert; the table holds buch_pkg::TableSlots (1024) slots. After
// reset a clearing pass writes one slot per cycle, and no word is accepted until it has
// covered every slot. One word is handled at a time through one memory with a write port and
// a registered read port, and every probe is an address step, then a registered read. Search
// and remove accept the word, probe the hashes in order until the key is found or all have
// been probed, and hand the result over. An insert accepts the word, probes for a free slot,
// reads and rewrites a slot for each displaced key, writes the key into a slot found free,
// and hands the result over. Moves between the last two hashes are capped by the relocation
// limit register; moves of an evicted key up to hash NUM_HASH-2 are not counted.
// The result sits in an output register, so the next word is accepted while it waits; a
// finished word stalls only while the previous result has not been taken.
module bubble_up_cuckoo_hash_table #(
  parameter int NUM_HASH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // key[30:0]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // success[0], dropped_valid[1], dropped_key[32:2]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data
);
  localparam int AW = $clog2(buch_pkg::TableSlots);
  localparam int CW = $clog2(NUM_HASH + 1);
  localparam int EW = 1 + buch_pkg::KeyW + CW;
  localparam int RW = buch_pkg::RelocW;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_PROBE = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_PLACE = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_SWAP  = 3'd6;
  localparam logic [2:0] ST_DONE  = 3'd7;

  logic [EW-1:0] mem [buch_pkg::TableSlots];
  logic [EW-1:0] rdata;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata;

  logic [2:0] state;
  logic [AW-1:0] clr;
  logic [30:0] seed [4];
  logic [RW-1:0] max_rel, reloc;
  logic [1:0]  kind;
  buch_pkg::key_t xk;
  logic [CW-1:0] xc, c;
  logic [AW-1:0] pos;
  logic [1:0] res;
  buch_pkg::key_t res_key;
  logic [32:0] out_word;

  logic [CW-1:0] D;
  assign D = CW'(NUM_HASH);

  function automatic logic [AW-1:0] slot_of(input logic [CW-1:0] i, input buch_pkg::key_t k,
                                            input logic [30:0] s0, input logic [30:0] s1,
                                            input logic [30:0] s2, input logic [30:0] s3);
    logic [30:0] s;
    logic [CW-1:0] j;
    j = (i >= CW'(NUM_HASH)) ? CW'(NUM_HASH - 1) : i;
    case (j[1:0])
      2'd0: s = s0;
      2'd1: s = s1;
      2'd2: s = s2;
      default: s = s3;
    endcase
    if (int'(j) >= 4) s = ~s;
    slot_of = AW'(k ^ s);
  endfunction

  logic [AW-1:0] probe_addr;
  assign probe_addr = slot_of(c, xk, seed[0], seed[1], seed[2], seed[3]);

  logic r_valid;
  buch_pkg::key_t r_key;
  logic [CW-1:0] r_choice;
  assign r_valid  = rdata[EW-1];
  assign r_key    = rdata[EW-2 -: buch_pkg::KeyW];
  assign r_choice = rdata[CW-1:0];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign s_tready = (state == ST_IDLE);
  assign m_tdata = {7'd0, out_word};

  always_comb begin
    we = 1'b0;
    waddr = pos;
    wdata = '0;
    raddr = probe_addr;
    if (state == ST_CLEAR) begin
      we = 1'b1;
      waddr = clr;
    end else if (state == ST_PLACE) begin
      we = 1'b1;
      wdata = {1'b1, xk, xc};
    end else if (state == ST_SWAP) begin
      we = 1'b1;
      wdata = {1'b1, xk, xc};
    end else if (state == ST_CHECK && kind == buch_pkg::KIND_REMOVE && r_valid
                 && r_key == xk) begin
      we = 1'b1;
    end
    if (state == ST_READ || state == ST_PLACE) raddr = pos;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr <= '0;
      seed[0] <= 31'd1;
      seed[1] <= 31'd2;
      seed[2] <= 31'd3;
      seed[3] <= 31'd4;
      max_rel <= 8'd41;
      m_tvalid <= 1'b0;
      out_word <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          buch_pkg::REG_SEED0: seed[0] <= cfg_data;
          buch_pkg::REG_SEED1: seed[1] <= cfg_data;
          buch_pkg::REG_SEED2: seed[2] <= cfg_data;
          buch_pkg::REG_SEED3: seed[3] <= cfg_data;
          buch_pkg::REG_MAXREL: max_rel <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (state == ST_DONE && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr <= clr + AW'(1);
          if (clr == AW'(buch_pkg::TableSlots - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            kind <= s_tuser;
            xk <= s_tdata[30:0];
            res <= '0;
            res_key <= '0;
            reloc <= '0;
            if (s_tuser == buch_pkg::KIND_INSERT) begin
              xc <= '0;
              c <= '0;
              if (max_rel == '0) begin
                res <= 2'b10;
                res_key <= s_tdata[30:0];
                state <= ST_DONE;
              end else begin
                state <= ST_PROBE;
              end
            end else if (s_tuser == buch_pkg::KIND_SEARCH ||
                         s_tuser == buch_pkg::KIND_REMOVE) begin
              c <= '0;
              state <= ST_PROBE;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_PROBE: begin
          // c holds the hash index (choice-1) being read.
          pos <= probe_addr;
          state <= ST_CHECK;
        end
        ST_CHECK: begin
          if (kind == buch_pkg::KIND_INSERT) begin
            if (!r_valid) begin
              xc <= c + CW'(1);
              state <= ST_PLACE;
            end else if (c + CW'(2) < D - CW'(1)) begin
              c <= c + CW'(1);
              state <= ST_PROBE;
            end else begin
              xc <= D - CW'(1);
              pos <= slot_of(D - CW'(2), xk, seed[0], seed[1], seed[2], seed[3]);
              state <= ST_READ;
            end
          end else begin
            if (r_valid && r_key == xk) begin
              res <= 2'b01;
              state <= ST_DONE;
            end else if (c == D - CW'(1)) begin
              state <= ST_DONE;
            end else begin
              c <= c + CW'(1);
              state <= ST_PROBE;
            end
          end
        end
        ST_PLACE: begin
          // Target known free from the probe.
          res <= 2'b01;
          state <= ST_DONE;
        end
        ST_READ: begin
          state <= ST_SWAP;
        end
        ST_SWAP: begin
          if (!r_valid) begin
            res <= 2'b01;
            state <= ST_DONE;
          end else begin
            xk <= r_key;
            xc <= r_choice;
            if (reloc >= max_rel) begin
              res <= 2'b10;
              res_key <= r_key;
              state <= ST_DONE;
            end else if (r_choice == D) begin
              xc <= D - CW'(1);
              reloc <= reloc + RW'(1);
              pos <= slot_of(D - CW'(2), r_key, seed[0], seed[1], seed[2], seed[3]);
              state <= ST_READ;
            end else if (r_choice == D - CW'(1)) begin
              xc <= D;
              reloc <= reloc + RW'(1);
              pos <= slot_of(D - CW'(1), r_key, seed[0], seed[1], seed[2], seed[3]);
              state <= ST_READ;
            end else begin
              c <= r_choice;
              if (r_choice + CW'(2) < D) begin
                state <= ST_PROBE;
              end else begin
                xc <= D - CW'(1);
                pos <= slot_of(D - CW'(2), r_key, seed[0], seed[1], seed[2], seed[3]);
                state <= ST_READ;
              end
            end
          end
        end
        ST_DONE: begin
          if (!m_tvalid || m_tready) begin
            out_word <= {res_key, res};
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule
